FILE: rtl/rucf_pkg.sv
// shared types and constants for the rotation unique code filter
// used by the controller, datapath and top level; no dependencies

package rucf_pkg;

  localparam int MAX_BITS_DEF    = 12;
  localparam int STORE_DEPTH_DEF = 512;
  localparam int CFG_W           = 4;

  localparam logic [CFG_W-1:0] CODE_BITS_RST = 4'd8;

  // manchester pairs
  localparam logic [1:0] MAN_ZERO = 2'b01;
  localparam logic [1:0] MAN_ONE  = 2'b10;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_SYM    = 2'd1,
    VERDICT_DUP    = 2'd2,
    VERDICT_FULL   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic load;
    logic rot_step;
    logic scan_start;
    logic scan_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rot_done;
    logic sym;
    logic scan_done;
  } dp_sts_t;

endpackage

FILE: rtl/rucf_store.sv
// code store: one write port, one registered read port
// no package dependencies

module rucf_store #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rucf_dpath.sv
// datapath: code width register, manchester encoder, rotation unit,
// canonical minimum, store scan and result registers
// depends on rucf_pkg and rucf_store

module rucf_dpath #(
  parameter int MAX_BITS    = rucf_pkg::MAX_BITS_DEF,
  parameter int STORE_DEPTH = rucf_pkg::STORE_DEPTH_DEF,
  parameter int IW          = $clog2(STORE_DEPTH),
  parameter int CNTW        = $clog2(STORE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rucf_pkg::CFG_W-1:0]   cfg_code_bits,
  input  logic [MAX_BITS-1:0]          id_value,
  input  rucf_pkg::ctrl_cmd_t          cmd,
  output rucf_pkg::dp_sts_t            sts,
  output rucf_pkg::verdict_t           verdict,
  output logic [IW-1:0]                entry_index,
  output logic [CNTW-1:0]              stored_count
);

  localparam int CW = 2 * MAX_BITS;
  localparam int KW = $clog2(MAX_BITS + 1);
  localparam int LW = KW + 1;
  localparam int SW = $clog2(CW);

  logic [rucf_pkg::CFG_W-1:0] code_bits_r;
  logic [KW-1:0]              k_eff;
  logic [KW-1:0]              k_r;
  logic [LW-1:0]              len_r;
  logic [LW-1:0]              len_m1;
  logic [SW-1:0]              msb_sel;
  logic [CW-1:0]              code_enc;
  logic [CW-1:0]              code_r;
  logic [CW-1:0]              rot_r;
  logic [CW-1:0]              rot_nxt;
  logic [CW-1:0]              len_mask;
  logic [CW-1:0]              canon_r;
  logic [LW-1:0]              step_r;
  logic                       sym_r;
  logic [CNTW-1:0]            addr_r;
  logic [CNTW-1:0]            count_r;
  logic                       rd_vld_r;
  logic                       hit_r;
  logic                       issue;
  logic                       full;
  logic [CW-1:0]              rd_data;
  rucf_pkg::verdict_t         verdict_c;
  logic                       store_we;

  // effective code width
  always_comb begin
    if (code_bits_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(code_bits_r) > MAX_BITS) begin
      k_eff = KW'(MAX_BITS);
    end else begin
      k_eff = KW'(code_bits_r);
    end
  end

  // msb first manchester: id bit i lands in pair i
  always_comb begin
    code_enc = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (i < int'(k_eff)) begin
        code_enc[2*i +: 2] = id_value[i] ? rucf_pkg::MAN_ONE : rucf_pkg::MAN_ZERO;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      len_mask[i] = (i < int'(len_r));
    end
  end

  assign len_m1  = len_r - LW'(1);
  assign msb_sel = len_m1[SW-1:0];
  assign rot_nxt = ({rot_r[CW-2:0], 1'b0} & len_mask) | CW'(rot_r[msb_sel]);

  assign issue = (addr_r < count_r);
  assign full  = (count_r == CNTW'(STORE_DEPTH));

  always_comb begin
    if (sym_r) begin
      verdict_c = rucf_pkg::VERDICT_SYM;
    end else if (hit_r) begin
      verdict_c = rucf_pkg::VERDICT_DUP;
    end else if (full) begin
      verdict_c = rucf_pkg::VERDICT_FULL;
    end else begin
      verdict_c = rucf_pkg::VERDICT_ACCEPT;
    end
  end

  assign store_we = cmd.commit && (verdict_c == rucf_pkg::VERDICT_ACCEPT);

  assign sts.rot_done  = (step_r == len_m1);
  assign sts.sym       = sym_r;
  assign sts.scan_done = hit_r || (!issue && !rd_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bits_r <= rucf_pkg::CODE_BITS_RST;
    end else if (cfg_we) begin
      code_bits_r <= cfg_code_bits;
    end
  end

  // rotation unit and canonical minimum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r  <= code_enc;
      rot_r   <= code_enc;
      canon_r <= code_enc;
      k_r     <= k_eff;
      len_r   <= {k_eff, 1'b0};
      step_r  <= '0;
    end else if (cmd.rot_step) begin
      rot_r  <= rot_nxt;
      step_r <= step_r + LW'(1);
      if (rot_nxt < canon_r) begin
        canon_r <= rot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= 1'b0;
    end else if (cmd.load) begin
      sym_r <= 1'b0;
    end else if (cmd.rot_step && (step_r < LW'(k_r)) && (rot_nxt == code_r)) begin
      sym_r <= 1'b1;
    end
  end

  // store scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.scan_start) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      addr_r   <= addr_r + CNTW'(issue);
      rd_vld_r <= issue;
      if (rd_vld_r && (rd_data == canon_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (store_we) begin
      count_r <= count_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      verdict      <= verdict_c;
      entry_index  <= store_we ? count_r[IW-1:0] : '0;
      stored_count <= store_we ? count_r + CNTW'(1) : count_r;
    end
  end

  rucf_store #(
    .WIDTH (CW),
    .DEPTH (STORE_DEPTH),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IW-1:0]),
    .wdata (canon_r),
    .re    (cmd.scan_step && issue),
    .raddr (addr_r[IW-1:0]),
    .rdata (rd_data)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(STORE_DEPTH))
    else $error("store count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |=> count_r == $past(count_r) + CNTW'(1))
    else $error("accepted code did not advance count");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !store_we) |=> entry_index == '0)
    else $error("rejected code got a nonzero index");
`endif

endmodule

FILE: rtl/rucf_ctrl.sv
// controller: sequences encode, rotation, store scan and result commit
// depends on rucf_pkg

module rucf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output rucf_pkg::ctrl_cmd_t  cmd,
  input  rucf_pkg::dp_sts_t    sts
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (!sts.rot_done) begin
          cmd.rot_step = 1'b1;
        end else if (sts.sym) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over a pending one");

  a_accept_rot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_ROT))
    else $error("accepted item did not start rotation");

  a_no_scan_sym: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !sts.sym)
    else $error("store scanned for a symmetric code");
`endif

endmodule

FILE: rtl/rotation_unique_code_filter_core.sv
// top level of the rotation unique code filter
// depends on rucf_pkg, rucf_ctrl, rucf_dpath
//
// channel  direction  handshake              payload
// in       slave      in_tvalid/in_tready    in_tdata: id_value
// out      master     out_tvalid/out_tready  out_tdata: verdict, entry_index, stored_count
// cfg      slave      cfg_valid/cfg_ready    cfg_data: code_bits
//
// an item is worked on at one rotation per cycle, then the store is scanned at one entry read
// per cycle through the single read port
// reset clears the store count and sets code_bits to 8; the store itself is not cleared
// one finished result waits in the output register while the next item is worked on

module rotation_unique_code_filter_core #(
  parameter int MAX_BITS    = rucf_pkg::MAX_BITS_DEF,
  parameter int STORE_DEPTH = rucf_pkg::STORE_DEPTH_DEF,
  localparam int IW         = $clog2(STORE_DEPTH),
  localparam int CNTW       = $clog2(STORE_DEPTH + 1),
  localparam int INW        = ((MAX_BITS + 7) / 8) * 8,
  localparam int OUTW       = ((2 + IW + CNTW + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [INW-1:0]             in_tdata,   // id_value
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUTW-1:0]            out_tdata,  // verdict, entry_index, stored_count
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rucf_pkg::CFG_W-1:0] cfg_data    // code_bits
);

  rucf_pkg::ctrl_cmd_t cmd;
  rucf_pkg::dp_sts_t   sts;
  rucf_pkg::verdict_t  verdict;
  logic [IW-1:0]       entry_index;
  logic [CNTW-1:0]     stored_count;

  assign cfg_ready = 1'b1;
  assign out_tdata = OUTW'({stored_count, entry_index, verdict});

  rucf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rucf_dpath #(
    .MAX_BITS    (MAX_BITS),
    .STORE_DEPTH (STORE_DEPTH),
    .IW          (IW),
    .CNTW        (CNTW)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_code_bits (cfg_data),
    .id_value      (in_tdata[MAX_BITS-1:0]),
    .cmd           (cmd),
    .sts           (sts),
    .verdict       (verdict),
    .entry_index   (entry_index),
    .stored_count  (stored_count)
  );

endmodule
